// File: hdl/dssf_pkg.sv
// ----------------------------------------------------------------------------
// dssf_pkg
// Shared widths, types and constants of the dual sensor spike filter.
// ----------------------------------------------------------------------------
package dssf_pkg;

  localparam int TEMP_W = 11;
  localparam int HUMI_W = 10;
  localparam int WIN_W  = 10;
  // Both channels run on a signed word wide enough for either reading.
  localparam int CHAN_W = 11;

  localparam logic [WIN_W-1:0] WIN_RESET = 10'd10;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic        [HUMI_W-1:0] humi_t;
  typedef logic        [WIN_W-1:0]  win_t;
  typedef logic signed [CHAN_W-1:0] chan_t;

  typedef struct packed {
    logic fire;
    logic first;
    win_t window;
  } chan_ctrl_t;

  typedef struct packed {
    chan_t value;
    logic  changed;
  } chan_res_t;

endpackage

// File: hdl/dssf_if.sv
// ----------------------------------------------------------------------------
// dssf_if
// Valid/ready channels of the spike filter: readings, results, window writes.
// ----------------------------------------------------------------------------
interface dssf_in_if import dssf_pkg::*;
();
  logic  valid;
  logic  ready;
  temp_t temp_sample;
  humi_t humi_sample;

  modport source (output valid, output temp_sample, output humi_sample, input ready);
  modport sink   (input valid, input temp_sample, input humi_sample, output ready);
endinterface

interface dssf_out_if import dssf_pkg::*;
();
  logic  valid;
  logic  ready;
  temp_t temp_value;
  logic  temp_changed;
  humi_t humi_value;
  logic  humi_changed;

  modport source (output valid, output temp_value, output temp_changed,
                  output humi_value, output humi_changed, input ready);
  modport sink   (input valid, input temp_value, input temp_changed,
                  input humi_value, input humi_changed, output ready);
endinterface

interface dssf_cfg_if import dssf_pkg::*;
();
  logic valid;
  logic ready;
  win_t outlier_window;

  modport source (output valid, output outlier_window, input ready);
  modport sink   (input valid, input outlier_window, output ready);
endinterface

// File: hdl/dssf_chan.sv
// ----------------------------------------------------------------------------
// dssf_chan
// One filter channel: history ring, running sum, average and spike decision.
// ----------------------------------------------------------------------------
module dssf_chan import dssf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  chan_ctrl_t                 ctrl_i,
  input  logic [$clog2(DEPTH)-1:0]   slot_i,
  input  chan_t                      sample_i,
  output chan_res_t                  res_o
);

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int SUM_W  = CHAN_W + SLOT_W;
  localparam int DIFF_W = CHAN_W + 1;
  localparam int SHIFT  = SUM_W + SLOT_W;
  localparam int PROD_W = SUM_W + SHIFT;
  // Rounded-up reciprocal; exact quotient for every magnitude below 2**SUM_W.
  localparam logic [SHIFT-1:0] RECIP =
    SHIFT'(((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));
  localparam logic signed [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

  chan_t                    ring_q [DEPTH];
  chan_t                    last_q;
  logic signed [SUM_W-1:0]  sum_q;

  logic                     sum_neg;
  logic        [SUM_W-1:0]  sum_mag;
  logic        [PROD_W-1:0] prod;
  logic        [SUM_W-1:0]  quot;
  chan_t                    avg_div;
  chan_t                    avg;
  chan_t                    accepted;
  chan_t                    old_entry;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] win_pos;
  logic signed [SUM_W-1:0]  sum_fill;
  logic signed [SUM_W-1:0]  sum_upd;
  logic                     changed;
  logic                     spike;

  always_comb begin
    // The average truncates toward zero, so the magnitude is divided.
    sum_neg  = sum_q[SUM_W-1];
    sum_mag  = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    prod     = PROD_W'(sum_mag) * PROD_W'(RECIP);
    quot     = prod[PROD_W-1:SHIFT];
    avg_div  = sum_neg ? CHAN_W'(-quot) : CHAN_W'(quot);
    // On the first reading the ring is being filled with the reading itself.
    avg      = ctrl_i.first ? sample_i : avg_div;

    diff     = DIFF_W'(sample_i) - DIFF_W'(last_q);
    win_pos  = DIFF_W'($signed({1'b0, ctrl_i.window}));
    spike    = (diff > win_pos) || (diff < -win_pos);
    changed  = (sample_i != last_q);
    accepted = spike ? avg : sample_i;

    old_entry = ring_q[slot_i];
    sum_fill  = SUM_W'(sample_i) * DEPTH_S;
    sum_upd   = sum_q - SUM_W'(old_entry) + SUM_W'(accepted);

    res_o.value   = changed ? accepted : last_q;
    res_o.changed = changed;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire) begin
      if (ctrl_i.first) begin
        for (int k = 0; k < DEPTH; k++) begin
          ring_q[k] <= sample_i;
        end
        sum_q <= sum_fill;
      end else if (changed) begin
        ring_q[slot_i] <= accepted;
        sum_q          <= sum_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (ctrl_i.fire && changed) begin
      last_q <= accepted;
    end
  end

endmodule

// File: hdl/dual_sensor_spike_filter_top.sv
// ----------------------------------------------------------------------------
// dual_sensor_spike_filter_top
// Spike filter for paired temperature and humidity readings, in tenths.
// ----------------------------------------------------------------------------
//   Channel  Dir  Payload                                         Request
//   cfg_i    in   outlier_window                                  one window write
//   in_i     in   temp_sample, humi_sample                        one reading pair
//   out_o    out  temp_value, temp_changed, humi_value,           one filtered pair
//                 humi_changed
//
// A reading pair is taken into an input register and filtered from there
// into the result register, which presents it until it is taken. One
// request is accepted per cycle while the result register is not stalled;
// the filter step holds the average, the window compare and the
// running-sum update of each channel. A stalled result register stalls the
// input register, and input ready drops only when both are full and the
// result is not being taken. Reset clears the valid flags and the slot,
// loads the default window and arms the ring fill for the first reading.
// ----------------------------------------------------------------------------
module dual_sensor_spike_filter_top import dssf_pkg::*;
#(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dssf_cfg_if.sink    cfg_i,
  dssf_in_if.sink     in_i,
  dssf_out_if.source  out_o
);

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

  win_t              win_q;
  logic              s1_valid_q, s1_valid_d;
  temp_t             s1_temp_q;
  humi_t             s1_humi_q;
  logic              first_q;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              out_valid_q, out_valid_d;
  temp_t             out_temp_q;
  logic              out_tchg_q;
  humi_t             out_humi_q;
  logic              out_hchg_q;

  logic              out_free;
  logic              s1_fire;
  logic              in_fire;
  chan_ctrl_t        ctrl;
  chan_res_t         temp_res;
  chan_res_t         humi_res;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    out_free   = !out_valid_q || out_o.ready;
    s1_fire    = s1_valid_q && out_free;
    in_i.ready = !s1_valid_q || out_free;
    in_fire    = in_i.valid && in_i.ready;

    s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    out_valid_d = s1_fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
    slot_d      = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;

    ctrl.fire   = s1_fire;
    ctrl.first  = first_q;
    ctrl.window = win_q;

    out_o.valid        = out_valid_q;
    out_o.temp_value   = out_temp_q;
    out_o.temp_changed = out_tchg_q;
    out_o.humi_value   = out_humi_q;
    out_o.humi_changed = out_hchg_q;
  end

  dssf_chan #(.DEPTH(HISTORY_DEPTH)) u_temp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .slot_i   (slot_q),
    .sample_i (CHAN_W'(s1_temp_q)),
    .res_o    (temp_res)
  );

  dssf_chan #(.DEPTH(HISTORY_DEPTH)) u_humi (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .slot_i   (slot_q),
    .sample_i ($signed({1'b0, s1_humi_q})),
    .res_o    (humi_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WIN_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      first_q     <= 1'b1;
      slot_q      <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        win_q <= cfg_i.outlier_window;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        first_q <= 1'b0;
        slot_q  <= slot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_temp_q <= in_i.temp_sample;
      s1_humi_q <= in_i.humi_sample;
    end
    if (s1_fire) begin
      out_temp_q <= TEMP_W'(temp_res.value);
      out_tchg_q <= temp_res.changed;
      out_humi_q <= HUMI_W'(humi_res.value);
      out_hchg_q <= humi_res.changed;
    end
  end

`ifndef SYNTHESIS
  // The ring fill is disarmed only by a pair leaving the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(first_q) |-> $past(s1_fire))
    else $error("first-reading flag cleared without a processed pair");

  // Once disarmed, the ring fill never comes back before a reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_q |=> !first_q)
    else $error("first-reading flag set again without reset");

  // The slot wraps to zero after the last ring entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (slot_q == SLOT_LAST) |=> slot_q == '0)
    else $error("slot pointer failed to wrap");

  // A request taken while the input register is full must see it drain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s1_valid_q |-> s1_fire)
    else $error("input register overwritten before it was processed");

  // Every processed pair lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("processed pair did not produce a result");
`endif

endmodule

// File: tb/dual_sensor_spike_filter_top_test.sv
// ----------------------------------------------------------------------------
// dual_sensor_spike_filter_top_test
// Self-checking bench for the spike filter. A queue of reading pairs feeds a
// valid/ready driver. Each accepted request is run through a local model of
// the history rings, and the filtered pairs that come out are compared field
// by field. The run covers several outlier windows, the extremes among them,
// and phases with and without idle cycles on both sides.
// ----------------------------------------------------------------------------
module dual_sensor_spike_filter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dssf_pkg::*;

  localparam int RING_DEPTH   = 4;
  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 10;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 225;
  localparam int PHASES       = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int TEMP_MIN     = -1024;
  localparam int TEMP_MAX     = 1023;
  localparam int TEMP_LO      = -400;
  localparam int TEMP_HI      = 800;
  localparam int HUMI_MAX     = 1023;
  localparam int HUMI_HI      = 1000;

  typedef struct packed {
    temp_t temp;
    humi_t humi;
  } reading_t;

  typedef struct packed {
    temp_t temp_value;
    logic  temp_changed;
    humi_t humi_value;
    logic  humi_changed;
  } filtered_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dssf_cfg_if cfg_if ();
  dssf_in_if  in_if ();
  dssf_out_if out_if ();

  dual_sensor_spike_filter_top #(
    .HISTORY_DEPTH(RING_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  reading_t  reading_q[$];
  filtered_t filtered_q[$];

  // Local copy of the filter state.
  int          temp_ring[RING_DEPTH];
  int          humi_ring[RING_DEPTH];
  int          temp_last;
  int          humi_last;
  int          window;
  int unsigned slot;
  bit          fill_pending;

  bit reading_taken;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;
  int mismatches;
  int readings_taken;
  int results_seen;
  int windows_written;
  int spikes_replaced;

  function automatic int screened(int sample, int last, int mean, int win);
    if (sample > last + win || sample < last - win) return mean;
    return sample;
  endfunction

  task automatic predict_filtered(temp_t t, humi_t h);
    int        ts;
    int        hs;
    int        tsum;
    int        hsum;
    filtered_t f;
    ts = $signed(t);
    hs = h;
    if (fill_pending) begin
      for (int k = 0; k < RING_DEPTH; k++) begin
        temp_ring[k] = ts;
        humi_ring[k] = hs;
      end
      fill_pending = 1'b0;
    end
    tsum = 0;
    hsum = 0;
    for (int k = 0; k < RING_DEPTH; k++) begin
      tsum += temp_ring[k];
      hsum += humi_ring[k];
    end
    f.temp_changed = (ts != temp_last);
    if (f.temp_changed) begin
      temp_last = screened(ts, temp_last, tsum / RING_DEPTH, window);
      if (temp_last != ts) spikes_replaced++;
      temp_ring[slot] = temp_last;
    end
    f.humi_changed = (hs != humi_last);
    if (f.humi_changed) begin
      humi_last = screened(hs, humi_last, hsum / RING_DEPTH, window);
      if (humi_last != hs) spikes_replaced++;
      humi_ring[slot] = humi_last;
    end
    slot = (slot + 1) % RING_DEPTH;
    f.temp_value = temp_t'(temp_last);
    f.humi_value = humi_t'(humi_last);
    filtered_q.push_back(f);
  endtask

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
  endtask

  // Requests and window writes are sampled at the rising edge.
  always @(posedge clk_i) begin
    reading_taken = in_if.valid && in_if.ready;
    if (cfg_if.valid && cfg_if.ready) begin
      window = cfg_if.outlier_window;
      windows_written++;
    end
    if (reading_taken) begin
      predict_filtered(in_if.temp_sample, in_if.humi_sample);
      void'(reading_q.pop_front());
      readings_taken++;
    end
  end

  // A request stays on the bus until it is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || reading_taken) begin
      if (reading_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid       <= 1'b1;
        in_if.temp_sample <= reading_q[0].temp;
        in_if.humi_sample <= reading_q[0].humi;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    filtered_t want;
    if (out_if.valid && out_if.ready) begin
      results_seen++;
      if (filtered_q.size() == 0) begin
        report($sformatf("filtered pair temp %0d humi %0d with no request outstanding",
                         $signed(out_if.temp_value), out_if.humi_value));
      end else begin
        want = filtered_q.pop_front();
        if (out_if.temp_value !== want.temp_value)
          report($sformatf("temp_value expected %0d, got %0d",
                           $signed(want.temp_value), $signed(out_if.temp_value)));
        if (out_if.temp_changed !== want.temp_changed)
          report($sformatf("temp_changed expected %0b, got %0b",
                           want.temp_changed, out_if.temp_changed));
        if (out_if.humi_value !== want.humi_value)
          report($sformatf("humi_value expected %0d, got %0d",
                           want.humi_value, out_if.humi_value));
        if (out_if.humi_changed !== want.humi_changed)
          report($sformatf("humi_changed expected %0b, got %0b",
                           want.humi_changed, out_if.humi_changed));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles.", STALL_LIMIT);
        $display("dual_sensor_spike_filter_top_test: done, errors");
        $finish;
      end
    end
  end

  task automatic queue_reading(int t, int h);
    reading_t r;
    r.temp = temp_t'(t);
    r.humi = humi_t'(h);
    reading_q.push_back(r);
  endtask

  task automatic wait_idle();
    while (reading_q.size() > 0 || filtered_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(int w);
    @(negedge clk_i);
    cfg_if.valid          <= 1'b1;
    cfg_if.outlier_window <= win_t'(w);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly steps inside the window, with repeats, steps at and just beyond the
  // window edge, spikes across the nominal range and values across the full range.
  function automatic int next_sample(int prev, int win, int lo, int hi,
                                     int nom_lo, int nom_hi);
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 45) v = prev - win + int'($urandom_range(2 * win));
    else if (pick < 60) v = prev;
    else if (pick < 72) v = prev + ($urandom_range(1) ? 1 : -1) * (win + int'($urandom_range(1)));
    else if (pick < 87) v = nom_lo + int'($urandom_range(nom_hi - nom_lo));
    else v = lo + int'($urandom_range(hi - lo));
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  initial begin : run
    int windows[PHASES];
    int send_pct[4];
    int recv_pct[4];
    int t_walk;
    int h_walk;

    windows  = '{0, 1023, 1, 10, 50, 0, 1022, 5};
    windows[5] = $urandom_range(2, 1021);
    send_pct = '{0, 62, 0, 10};
    recv_pct = '{0, 0, 62, 10};

    cfg_if.valid          = 1'b0;
    cfg_if.outlier_window = '0;
    rst_ni                = 1'b0;

    temp_last    = 0;
    humi_last    = 0;
    slot         = 0;
    fill_pending = 1'b1;
    window       = WIN_RESET;
    for (int k = 0; k < RING_DEPTH; k++) begin
      temp_ring[k] = 0;
      humi_ring[k] = 0;
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on the reset window. The first pair lies far from zero,
    // so the freshly filled ring average stands in for it. The second pair
    // is a spike whose substitute equals the last value.
    @(posedge clk_i);
    queue_reading(TEMP_LO, HUMI_HI);
    queue_reading(TEMP_HI, 0);
    queue_reading(TEMP_LO, HUMI_HI);
    queue_reading(-395, 995);
    queue_reading(-385, 985);
    queue_reading(-374, 974);
    queue_reading(-374, 974);
    queue_reading(TEMP_MAX, HUMI_MAX);
    queue_reading(TEMP_MIN, 0);
    queue_reading(0, 500);
    queue_reading(0, 500);
    queue_reading(10, 510);
    queue_reading(20, 520);
    queue_reading(9, 509);
    queue_reading(-1, 499);
    queue_reading(-1, 499);
    queue_reading(TEMP_HI, HUMI_HI);
    queue_reading(TEMP_LO, 0);
    queue_reading(TEMP_MIN, HUMI_MAX);
    queue_reading(TEMP_MAX, 0);
    wait_idle();

    t_walk = TEMP_MAX;
    h_walk = 0;
    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct  = send_pct[p % 4];
      recv_stall_pct = recv_pct[p % 4];
      write_window(windows[p]);
      @(posedge clk_i);
      repeat (PHASE_ITEMS) begin
        t_walk = next_sample(t_walk, windows[p], TEMP_MIN, TEMP_MAX, TEMP_LO, TEMP_HI);
        h_walk = next_sample(h_walk, windows[p], 0, HUMI_MAX, 0, HUMI_HI);
        queue_reading(t_walk, h_walk);
      end
      wait_idle();
    end

    if (filtered_q.size() > 0)
      report($sformatf("%0d filtered pairs never arrived", filtered_q.size()));
    $display("Covered %0d readings and %0d filtered pairs over %0d window writes.",
             readings_taken, results_seen, windows_written);
    $display("Spikes replaced by the ring average: %0d; mismatches: %0d.",
             spikes_replaced, mismatches);
    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("dual_sensor_spike_filter_top_test: done, clean");
    end else begin
      $display("dual_sensor_spike_filter_top_test: done, errors");
    end
    $finish;
  end

endmodule
